// File: src/rhf_pkg.sv
`default_nettype none
package rhf_pkg;

  localparam int TIME_BITS   = 16;
  localparam int HEIGHT_BITS = 32;
  localparam int FRAC_BITS   = 16;

  localparam int ELAP_W    = TIME_BITS + 1;
  localparam int Q_W       = FRAC_BITS + 1;
  localparam int MUL_A_W   = HEIGHT_BITS + 1;
  localparam int MUL_B_W   = FRAC_BITS + 2;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int CNT_W     = $clog2(FRAC_BITS);
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = (HEIGHT_BITS > TIME_BITS) ? HEIGHT_BITS : TIME_BITS;

  localparam logic [Q_W-1:0] ONE_Q = Q_W'(1) << FRAC_BITS;
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(FRAC_BITS - 1);

  // event kinds
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_START = 2'd1;
  localparam logic [1:0] KIND_STOP  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HEIGHT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RISE_TIME     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FALL_TIME     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HOVER_TIME    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_AUTO_RETURN   = 3'd4;

  typedef enum logic [1:0] {
    PH_STOP  = 2'd0,
    PH_RISE  = 2'd1,
    PH_HOVER = 2'd2,
    PH_FALL  = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_DIV,
    SEQ_SQR,
    SEQ_SCALE,
    SEQ_FIN
  } seq_e;

  typedef struct packed {
    logic [1:0]           kind;
    logic [TIME_BITS-1:0] delta_time;
  } in_item_t;

  typedef struct packed {
    logic signed [HEIGHT_BITS-1:0] offset;
    logic                          offset_written;
    logic [1:0]                    phase;
  } out_item_t;

  // commands from the sequencer to the arithmetic unit
  typedef struct packed {
    logic load;
    logic div_step;
    logic sqr;
    logic scale;
    logic rising;
  } unit_ctrl_t;

  typedef logic signed [MUL_A_W-1:0] mul_a_t;
  typedef logic signed [MUL_B_W-1:0] mul_b_t;

endpackage
`default_nettype wire

// File: src/rhf_unit.sv
`default_nettype none
module rhf_unit (
  input  wire logic                                clk_i,
  input  wire rhf_pkg::unit_ctrl_t                 ctrl_i,
  input  wire logic [rhf_pkg::TIME_BITS-1:0]       rem_init_i,
  input  wire logic [rhf_pkg::TIME_BITS-1:0]       divisor_i,
  input  wire logic signed [rhf_pkg::HEIGHT_BITS-1:0] height_i,
  output logic signed [rhf_pkg::HEIGHT_BITS-1:0]   offset_o
);

  logic [rhf_pkg::TIME_BITS-1:0]  rem_q, rem_d;
  logic [rhf_pkg::TIME_BITS-1:0]  div_q;
  logic [rhf_pkg::FRAC_BITS-1:0]  quo_q, quo_d;
  logic                           rising_q;
  logic signed [rhf_pkg::PROD_W-1:0] prod_q, prod_d;

  logic [rhf_pkg::TIME_BITS:0]    rem2;
  logic                           ge;
  logic [rhf_pkg::Q_W-1:0]        prog;
  logic [rhf_pkg::Q_W-1:0]        factor;
  rhf_pkg::mul_a_t                mul_a;
  rhf_pkg::mul_b_t                mul_b;

  // restoring division, one quotient bit a cycle
  always_comb begin
    rem2  = {rem_q, 1'b0};
    ge    = rem2 >= {1'b0, div_q};
    rem_d = ge ? rhf_pkg::TIME_BITS'(rem2 - {1'b0, div_q})
               : rem2[rhf_pkg::TIME_BITS-1:0];
    quo_d = {quo_q[rhf_pkg::FRAC_BITS-2:0], ge};
  end

  // shared multiplier: first the eased square, then the height scaling
  always_comb begin
    prog   = rising_q ? (rhf_pkg::ONE_Q - {1'b0, quo_q}) : {1'b0, quo_q};
    factor = rhf_pkg::ONE_Q - prod_q[rhf_pkg::FRAC_BITS +: rhf_pkg::Q_W];
    if (ctrl_i.scale) begin
      mul_a = rhf_pkg::mul_a_t'(height_i);
      mul_b = rhf_pkg::mul_b_t'(factor);
    end else begin
      mul_a = rhf_pkg::mul_a_t'(prog);
      mul_b = rhf_pkg::mul_b_t'(prog);
    end
    prod_d = rhf_pkg::PROD_W'(mul_a * mul_b);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      rem_q    <= rem_init_i;
      div_q    <= divisor_i;
      rising_q <= ctrl_i.rising;
      quo_q    <= '0;
    end else if (ctrl_i.div_step) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
    if (ctrl_i.sqr || ctrl_i.scale) begin
      prod_q <= prod_d;
    end
  end

  // arithmetic shift right by the fraction bits, truncated to height width
  assign offset_o = prod_q[rhf_pkg::FRAC_BITS +: rhf_pkg::HEIGHT_BITS];

endmodule
`default_nettype wire

// File: src/rise_hover_fall_motion_profile.sv
// rise / hover / fall motion profile: one beat in, one beat out
// eased offsets: the input beat is followed by 16 divider steps, the square, the height
//   scaling and the output load; the next input is taken once the sequencer is idle again
// other events: straight from the input beat to the output load, next input once idle again
// the sequencer waits in its final state while the output register holds an untaken result
// reset: asynchronous active low; stopped, elapsed and hover cleared, registers at defaults
`default_nettype none
module rise_hover_fall_motion_profile (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_ready_o,
  input  wire rhf_pkg::in_item_t                     in_data_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_ready_i,
  output rhf_pkg::out_item_t                         out_data_o,
  input  wire logic                                  cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire logic [rhf_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  wire logic [rhf_pkg::CFG_DAT_W-1:0]         cfg_data_i
);

  // configuration registers, used live
  logic signed [rhf_pkg::HEIGHT_BITS-1:0] height_q;
  logic [rhf_pkg::TIME_BITS-1:0]          rise_q;
  logic [rhf_pkg::TIME_BITS-1:0]          fall_q;
  logic [rhf_pkg::TIME_BITS-1:0]          hover_q;
  logic                                   auto_q;

  // motion state
  rhf_pkg::phase_e                        phase_q, phase_d;
  logic [rhf_pkg::ELAP_W-1:0]             elapsed_q, elapsed_d;
  logic [rhf_pkg::TIME_BITS-1:0]          hover_left_q, hover_left_d;

  // sequencer
  rhf_pkg::seq_e                          seq_q, seq_d;
  logic [rhf_pkg::CNT_W-1:0]              cnt_q;
  logic                                   wr_q, wr_d;
  logic                                   math_q, math_d;
  logic signed [rhf_pkg::HEIGHT_BITS-1:0] off_q, off_d;
  logic                                   rising_d;

  // output register
  logic                                   out_valid_q;
  rhf_pkg::out_item_t                     out_data_q;

  logic                                   in_acc;
  logic                                   out_free;
  logic                                   fin_load;
  rhf_pkg::unit_ctrl_t                    uctrl;
  logic signed [rhf_pkg::HEIGHT_BITS-1:0] unit_off;

  logic [rhf_pkg::ELAP_W:0]               el_sum;
  logic [rhf_pkg::ELAP_W-1:0]             el_sat;

  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q <= '0;
      rise_q   <= rhf_pkg::TIME_BITS'(1);
      fall_q   <= rhf_pkg::TIME_BITS'(1);
      hover_q  <= '0;
      auto_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        rhf_pkg::CFG_TARGET_HEIGHT: height_q <= cfg_data_i[rhf_pkg::HEIGHT_BITS-1:0];
        rhf_pkg::CFG_RISE_TIME:     rise_q   <= cfg_data_i[rhf_pkg::TIME_BITS-1:0];
        rhf_pkg::CFG_FALL_TIME:     fall_q   <= cfg_data_i[rhf_pkg::TIME_BITS-1:0];
        rhf_pkg::CFG_HOVER_TIME:    hover_q  <= cfg_data_i[rhf_pkg::TIME_BITS-1:0];
        rhf_pkg::CFG_AUTO_RETURN:   auto_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // elapsed time plus this tick, saturating
  always_comb begin
    el_sum = {1'b0, elapsed_q} + (rhf_pkg::ELAP_W + 1)'(in_data_i.delta_time);
    el_sat = el_sum[rhf_pkg::ELAP_W] ? '1 : el_sum[rhf_pkg::ELAP_W-1:0];
  end

  // event decode: new motion state and what the result beat carries
  always_comb begin
    phase_d      = phase_q;
    elapsed_d    = elapsed_q;
    hover_left_d = hover_left_q;
    wr_d         = 1'b0;
    math_d       = 1'b0;
    rising_d     = 1'b0;
    off_d        = '0;
    unique case (in_data_i.kind)
      rhf_pkg::KIND_START: begin
        if (rise_q != '0 && fall_q != '0) begin
          phase_d      = rhf_pkg::PH_RISE;
          elapsed_d    = '0;
          hover_left_d = '0;
        end
      end
      rhf_pkg::KIND_STOP: begin
        wr_d         = (phase_q != rhf_pkg::PH_STOP) && auto_q;
        phase_d      = rhf_pkg::PH_STOP;
        elapsed_d    = '0;
        hover_left_d = '0;
      end
      rhf_pkg::KIND_TICK: begin
        unique case (phase_q)
          rhf_pkg::PH_RISE: begin
            wr_d = 1'b1;
            if (el_sat < {1'b0, rise_q}) begin
              // still rising: eased offset through the arithmetic unit
              elapsed_d = el_sat;
              math_d    = 1'b1;
              rising_d  = 1'b1;
            end else begin
              // peak reached; the same tick already counts against the hover
              elapsed_d = '0;
              off_d     = height_q;
              if (hover_q != '0 && in_data_i.delta_time < hover_q) begin
                hover_left_d = hover_q - in_data_i.delta_time;
                phase_d      = rhf_pkg::PH_HOVER;
              end else begin
                phase_d = rhf_pkg::PH_FALL;
              end
            end
          end
          rhf_pkg::PH_HOVER: begin
            if (in_data_i.delta_time >= hover_left_q) begin
              hover_left_d = '0;
              elapsed_d    = '0;
              phase_d      = rhf_pkg::PH_FALL;
            end else begin
              hover_left_d = hover_left_q - in_data_i.delta_time;
            end
          end
          rhf_pkg::PH_FALL: begin
            if (el_sat >= {1'b0, fall_q}) begin
              // landed: optional return to zero
              wr_d         = auto_q;
              phase_d      = rhf_pkg::PH_STOP;
              elapsed_d    = '0;
              hover_left_d = '0;
            end else begin
              elapsed_d = el_sat;
              wr_d      = 1'b1;
              math_d    = 1'b1;
            end
          end
          rhf_pkg::PH_STOP: ;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // sequencer next state
  always_comb begin
    seq_d = seq_q;
    unique case (seq_q)
      rhf_pkg::SEQ_IDLE: begin
        if (in_valid_i) begin
          seq_d = math_d ? rhf_pkg::SEQ_DIV : rhf_pkg::SEQ_FIN;
        end
      end
      rhf_pkg::SEQ_DIV: begin
        if (cnt_q == rhf_pkg::DIV_LAST) begin
          seq_d = rhf_pkg::SEQ_SQR;
        end
      end
      rhf_pkg::SEQ_SQR:   seq_d = rhf_pkg::SEQ_SCALE;
      rhf_pkg::SEQ_SCALE: seq_d = rhf_pkg::SEQ_FIN;
      rhf_pkg::SEQ_FIN: begin
        if (out_free) begin
          seq_d = rhf_pkg::SEQ_IDLE;
        end
      end
      default: seq_d = rhf_pkg::SEQ_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o      = 1'b0;
    fin_load        = 1'b0;
    uctrl           = '0;
    uctrl.rising    = rising_d;
    unique case (seq_q)
      rhf_pkg::SEQ_IDLE: begin
        in_ready_o = 1'b1;
        uctrl.load = in_valid_i && math_d;
      end
      rhf_pkg::SEQ_DIV:   uctrl.div_step = 1'b1;
      rhf_pkg::SEQ_SQR:   uctrl.sqr      = 1'b1;
      rhf_pkg::SEQ_SCALE: uctrl.scale    = 1'b1;
      rhf_pkg::SEQ_FIN:   fin_load       = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q        <= rhf_pkg::SEQ_IDLE;
      cnt_q        <= '0;
      phase_q      <= rhf_pkg::PH_STOP;
      elapsed_q    <= '0;
      hover_left_q <= '0;
      wr_q         <= 1'b0;
      math_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      seq_q <= seq_d;
      if (seq_q == rhf_pkg::SEQ_DIV) begin
        cnt_q <= cnt_q + rhf_pkg::CNT_W'(1);
      end else begin
        cnt_q <= '0;
      end
      if (in_acc) begin
        phase_q      <= phase_d;
        elapsed_q    <= elapsed_d;
        hover_left_q <= hover_left_d;
        wr_q         <= wr_d;
        math_q       <= math_d;
      end
      if (fin_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      off_q <= off_d;
    end
    if (fin_load) begin
      out_data_q.offset         <= math_q ? unit_off : off_q;
      out_data_q.offset_written <= wr_q;
      out_data_q.phase          <= phase_q;
    end
  end

  // divider remainder starts at elapsed, which stays below the phase length here
  rhf_unit u_unit (
    .clk_i      (clk_i),
    .ctrl_i     (uctrl),
    .rem_init_i (elapsed_d[rhf_pkg::TIME_BITS-1:0]),
    .divisor_i  (rising_d ? rise_q : fall_q),
    .height_i   (height_q),
    .offset_o   (unit_off)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
`default_nettype wire
